FILE: rtl/pcapd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcapd_pkg
// Shared types, codes and constants of the capture-file deframer: magic
// values, header layout, result kinds, error codes and the beat structs.
// ----------------------------------------------------------------------------
package pcapd_pkg;

   // Largest legal snap length and captured length
   localparam int unsigned MAX_CAPTURE_BYTES = 64 * 1024 * 1024;
   localparam logic [31:0] MAX_CAPTURE_WORD  = 32'(MAX_CAPTURE_BYTES);

   // Link type expected after reset (Ethernet)
   localparam logic [31:0] LINK_TYPE_RESET = 32'd1;

   // Magic values as read in file order, most significant byte first
   localparam logic [31:0] MAGIC_LE_USEC      = 32'hd4c3b2a1;
   localparam logic [31:0] MAGIC_BE_USEC      = 32'ha1b2c3d4;
   localparam logic [31:0] MAGIC_LE_NSEC      = 32'h4d3cb2a1;
   localparam logic [31:0] MAGIC_BE_NSEC      = 32'ha1b23c4d;
   localparam logic [31:0] MAGIC_LE_MODIFIED  = 32'h34cdb2a1;
   localparam logic [31:0] MAGIC_BE_MODIFIED  = 32'ha1b2cd34;

   // Header byte positions of the final byte
   localparam logic [4:0] GLOBAL_LAST_BYTE       = 5'd23;
   localparam logic [4:0] SHORT_RECORD_LAST_BYTE = 5'd15;
   localparam logic [4:0] LONG_RECORD_LAST_BYTE  = 5'd23;

   // Word slots (byte position divided by four)
   localparam logic [2:0] SLOT_MAGIC    = 3'd0;
   localparam logic [2:0] SLOT_VERSION  = 3'd1;
   localparam logic [2:0] SLOT_SNAP     = 3'd4;
   localparam logic [2:0] SLOT_LINK     = 3'd5;
   localparam logic [2:0] SLOT_SECONDS  = 3'd0;
   localparam logic [2:0] SLOT_FRACTION = 3'd1;
   localparam logic [2:0] SLOT_CAPTURED = 3'd2;
   localparam logic [2:0] SLOT_ORIGINAL = 3'd3;

   typedef enum logic [1:0] {
      PHASE_GLOBAL = 2'd0,
      PHASE_RECORD = 2'd1,
      PHASE_DATA   = 2'd2,
      PHASE_STOP   = 2'd3
   } phase_type;

   typedef enum logic {
      CMD_BYTE = 1'b0,
      CMD_END  = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      KIND_GLOBAL = 3'd0,
      KIND_RECORD = 3'd1,
      KIND_DATA   = 3'd2,
      KIND_ERROR  = 3'd3,
      KIND_END    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE         = 3'd0,
      ERR_SHORT_GLOBAL = 3'd1,
      ERR_MAGIC        = 3'd2,
      ERR_LINK         = 3'd3,
      ERR_SNAPLEN      = 3'd4,
      ERR_SHORT_RECORD = 3'd5,
      ERR_CAPLEN       = 3'd6,
      ERR_SHORT_DATA   = 3'd7
   } error_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] stream_byte;
   } req_payload_type;

   typedef struct packed {
      kind_type    kind;
      error_type   error_code;
      logic        little_endian;
      logic        nanosecond_stamps;
      logic [31:0] format_version;
      logic [26:0] snapshot_length;
      logic [31:0] stamp_seconds;
      logic [31:0] stamp_fraction;
      logic [26:0] captured_length;
      logic [31:0] original_length;
      logic [7:0]  packet_byte;
      logic        last_of_packet;
   } rsp_payload_type;

   // Full byte reversal of a 32-bit word
   function automatic logic [31:0] swap32(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

   // Byte swap inside each 16-bit half
   function automatic logic [31:0] swap_halves(input logic [31:0] v);
      return {v[23:16], v[31:24], v[7:0], v[15:8]};
   endfunction

endpackage

FILE: rtl/pcap_stream_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcap_stream_deframer_core
// Streaming capture-file deframer: parses the global header, each record
// header and the packet data of a byte stream, one byte per beat.
//
//   Port group   Dir   Handshake         Carries
//   req_*        in    valid / ready     cmd, stream_byte
//   rsp_*        out   valid / ready     header fields, data byte, error, end
//   csr_*        in    write enable      required link type
//
// Throughput is one byte beat per clock while results are taken; an accepted
// beat is held in the input register, parsed by the per-beat logic and its
// result, if any, is offered from the result register.
// Reset is synchronous and returns the parser to the global header.
// A stalled result holds the result register and the parser; req_ready
// drops once the input register holds a beat, until the result leaves.
// After an error or a clean end no further results are given until reset.
// ----------------------------------------------------------------------------
module pcap_stream_deframer_core
   import pcapd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [31:0]     csr_write_data,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            item_valid;
   req_payload_type item_payload;
   logic            item_take;
   logic            res_valid;
   logic            res_ready;
   rsp_payload_type res_payload;

   pcapd_in_stage u_in_stage (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .item_valid   (item_valid),
      .item_payload (item_payload),
      .item_take    (item_take)
   );

   pcapd_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .item_valid       (item_valid),
      .item_payload     (item_payload),
      .item_take        (item_take),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res_payload      (res_payload)
   );

   pcapd_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_payload (res_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   // Error code is set exactly on error results
   a_error_code_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_payload.kind == KIND_ERROR) ==
                     (rsp_payload.error_code != ERR_NONE)))
      else $error("error code does not match result kind");

   // Data fields stay clear outside data beats
   a_data_fields_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind != KIND_DATA) |->
      (!rsp_payload.last_of_packet && rsp_payload.packet_byte == 8'd0))
      else $error("data fields set on a non-data result");

   // Global header result carries a nonzero snap length
   a_snap_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.kind == KIND_GLOBAL) |->
      (rsp_payload.snapshot_length != 27'd0))
      else $error("global header result with zero snap length");

   // Nothing follows a delivered error or end
   a_stop_after_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready &&
       (rsp_payload.kind == KIND_ERROR || rsp_payload.kind == KIND_END)) |=>
      !rsp_valid)
      else $error("result after error or end of stream");

endmodule

FILE: rtl/pcapd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcapd_in_stage
// Input register: captures one request beat and holds it until the parser
// takes it; refills in the same cycle so a beat can enter every clock.
// ----------------------------------------------------------------------------
module pcapd_in_stage
   import pcapd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            item_valid,
   output req_payload_type item_payload,
   input  logic            item_take
);

   logic            valid_ff;
   logic            valid_in;
   req_payload_type payload_ff;

   // Accept when empty or when the held beat leaves this cycle
   assign req_ready = !valid_ff || item_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (item_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load payload on accept, hold otherwise
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         payload_ff <= req_payload;
      end
   end

   assign item_valid   = valid_ff;
   assign item_payload = payload_ff;

endmodule

FILE: rtl/pcapd_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcapd_out_stage
// Result register: holds one response beat until the consumer takes it and
// reloads in the cycle the held beat leaves.
// ----------------------------------------------------------------------------
module pcapd_out_stage
   import pcapd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            res_valid,
   output logic            res_ready,
   input  rsp_payload_type res_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff;
   logic            valid_in;
   rsp_payload_type payload_ff;

   assign res_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (res_valid && res_ready) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         payload_ff <= res_payload;
      end
   end

   assign rsp_valid   = valid_ff;
   assign rsp_payload = payload_ff;

endmodule

FILE: rtl/pcapd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcapd_parser
// Parse state and per-byte logic: gathers global and record header words,
// checks them, counts data bytes and forms at most one result per beat.
// ----------------------------------------------------------------------------
module pcapd_parser
   import pcapd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_write_enable,
   input  logic [31:0]     csr_write_data,
   input  logic            item_valid,
   input  req_payload_type item_payload,
   output logic            item_take,
   output logic            res_valid,
   input  logic            res_ready,
   output rsp_payload_type res_payload
);

   // Control state
   phase_type   phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic        le_ff, le_in;
   logic        ns_ff, ns_in;
   logic        long_ff, long_in;
   logic        magic_known_ff, magic_known_in;
   logic [31:0] link_required_ff;

   // Header words and byte accumulator
   logic [23:0] shift_ff;
   logic [31:0] version_ff;
   logic [31:0] snap_ff;
   logic [31:0] seconds_ff;
   logic [31:0] fraction_ff;
   logic [31:0] captured_ff;
   logic [31:0] original_ff;
   logic [26:0] remaining_ff;

   // Per-beat decode
   logic        step;
   logic        is_end;
   logic [31:0] acc;
   logic [31:0] acc_word;
   logic        word_end;
   logic [2:0]  slot;
   logic [4:0]  record_last;
   logic        global_done;
   logic        record_done;
   logic        magic_hit, magic_le, magic_ns, magic_long;
   logic        global_ok;
   error_type   global_err;
   logic        snap_ok;
   logic        cap_ok;
   logic [31:0] original_cur;
   logic        data_last;

   assign step        = item_valid && res_ready;
   assign item_take   = step;
   assign is_end      = (item_payload.cmd == CMD_END);
   assign acc         = {shift_ff, item_payload.stream_byte};
   assign acc_word    = le_ff ? swap32(acc) : acc;
   assign word_end    = (count_ff[1:0] == 2'b11);
   assign slot        = count_ff[4:2];
   assign record_last = long_ff ? LONG_RECORD_LAST_BYTE : SHORT_RECORD_LAST_BYTE;
   assign global_done = (count_ff == GLOBAL_LAST_BYTE);
   assign record_done = (count_ff == record_last);
   assign data_last   = (remaining_ff == 27'd1);

   // Recognize the magic word
   always_comb begin
      magic_hit  = 1'b1;
      magic_le   = 1'b0;
      magic_ns   = 1'b0;
      magic_long = 1'b0;
      case (acc)
         MAGIC_LE_USEC:     magic_le = 1'b1;
         MAGIC_BE_USEC:     magic_le = 1'b0;
         MAGIC_LE_NSEC: begin
            magic_le = 1'b1;
            magic_ns = 1'b1;
         end
         MAGIC_BE_NSEC:     magic_ns = 1'b1;
         MAGIC_LE_MODIFIED: begin
            magic_le   = 1'b1;
            magic_long = 1'b1;
         end
         MAGIC_BE_MODIFIED: magic_long = 1'b1;
         default:           magic_hit = 1'b0;
      endcase
   end

   // Header checks; the link word arrives with the final global byte
   assign snap_ok = (snap_ff != 32'd0) && (snap_ff <= MAX_CAPTURE_WORD);
   assign cap_ok  = (captured_ff <= snap_ff) && (captured_ff <= MAX_CAPTURE_WORD);

   always_comb begin
      global_err = ERR_NONE;
      if (!magic_known_ff) begin
         global_err = ERR_MAGIC;
      end else if (acc_word != link_required_ff) begin
         global_err = ERR_LINK;
      end else if (!snap_ok) begin
         global_err = ERR_SNAPLEN;
      end
   end
   assign global_ok = (global_err == ERR_NONE);

   // Original length may complete on the final byte of a short header
   assign original_cur = (word_end && slot == SLOT_ORIGINAL) ? acc_word : original_ff;

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step) begin
         case (phase_ff)
            PHASE_GLOBAL: begin
               if (is_end) begin
                  phase_in = PHASE_STOP;
               end else if (global_done) begin
                  phase_in = global_ok ? PHASE_RECORD : PHASE_STOP;
               end
            end
            PHASE_RECORD: begin
               if (is_end) begin
                  phase_in = PHASE_STOP;
               end else if (record_done) begin
                  if (!cap_ok) begin
                     phase_in = PHASE_STOP;
                  end else if (captured_ff != 32'd0) begin
                     phase_in = PHASE_DATA;
                  end
               end
            end
            PHASE_DATA: begin
               if (is_end) begin
                  phase_in = PHASE_STOP;
               end else if (data_last) begin
                  phase_in = PHASE_RECORD;
               end
            end
            default: phase_in = phase_ff;
         endcase
      end
   end

   // Result beat
   always_comb begin
      res_valid                     = 1'b0;
      res_payload                   = '0;
      res_payload.little_endian     = le_ff;
      res_payload.nanosecond_stamps = ns_ff;
      case (phase_ff)
         PHASE_GLOBAL: begin
            if (is_end) begin
               res_valid              = step;
               res_payload.kind       = KIND_ERROR;
               res_payload.error_code = ERR_SHORT_GLOBAL;
            end else if (global_done) begin
               res_valid = step;
               if (global_ok) begin
                  res_payload.kind            = KIND_GLOBAL;
                  res_payload.format_version  = version_ff;
                  res_payload.snapshot_length = snap_ff[26:0];
               end else begin
                  res_payload.kind       = KIND_ERROR;
                  res_payload.error_code = global_err;
               end
            end
         end
         PHASE_RECORD: begin
            if (is_end) begin
               res_valid = step;
               if (count_ff == 5'd0) begin
                  res_payload.kind = KIND_END;
               end else begin
                  res_payload.kind       = KIND_ERROR;
                  res_payload.error_code = ERR_SHORT_RECORD;
               end
            end else if (record_done) begin
               res_valid = step;
               if (cap_ok) begin
                  res_payload.kind            = KIND_RECORD;
                  res_payload.stamp_seconds   = seconds_ff;
                  res_payload.stamp_fraction  = fraction_ff;
                  res_payload.captured_length = captured_ff[26:0];
                  res_payload.original_length = original_cur;
               end else begin
                  res_payload.kind       = KIND_ERROR;
                  res_payload.error_code = ERR_CAPLEN;
               end
            end
         end
         PHASE_DATA: begin
            res_valid = step;
            if (is_end) begin
               res_payload.kind       = KIND_ERROR;
               res_payload.error_code = ERR_SHORT_DATA;
            end else begin
               res_payload.kind           = KIND_DATA;
               res_payload.packet_byte    = item_payload.stream_byte;
               res_payload.last_of_packet = data_last;
            end
         end
         default: res_valid = 1'b0;
      endcase
   end

   // Header byte count and format flags
   always_comb begin
      count_in       = count_ff;
      le_in          = le_ff;
      ns_in          = ns_ff;
      long_in        = long_ff;
      magic_known_in = magic_known_ff;
      if (step && !is_end) begin
         if (phase_ff == PHASE_GLOBAL) begin
            count_in = global_done ? 5'd0 : count_ff + 5'd1;
            if (word_end && slot == SLOT_MAGIC) begin
               magic_known_in = magic_hit;
               if (magic_hit) begin
                  le_in   = magic_le;
                  ns_in   = magic_ns;
                  long_in = magic_long;
               end
            end
         end else if (phase_ff == PHASE_RECORD) begin
            count_in = record_done ? 5'd0 : count_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PHASE_GLOBAL;
         count_ff         <= 5'd0;
         le_ff            <= 1'b0;
         ns_ff            <= 1'b0;
         long_ff          <= 1'b0;
         magic_known_ff   <= 1'b0;
         link_required_ff <= LINK_TYPE_RESET;
      end else begin
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         le_ff          <= le_in;
         ns_ff          <= ns_in;
         long_ff        <= long_in;
         magic_known_ff <= magic_known_in;
         if (csr_write_enable) begin
            link_required_ff <= csr_write_data;
         end
      end
   end

   // Gather header words, load and count down data bytes
   always_ff @(posedge clock) begin
      if (step && !is_end) begin
         case (phase_ff)
            PHASE_GLOBAL: begin
               shift_ff <= acc[23:0];
               if (word_end && slot == SLOT_VERSION) begin
                  version_ff <= le_ff ? swap_halves(acc) : acc;
               end
               if (word_end && slot == SLOT_SNAP) begin
                  snap_ff <= acc_word;
               end
            end
            PHASE_RECORD: begin
               shift_ff <= acc[23:0];
               if (word_end && slot == SLOT_SECONDS) begin
                  seconds_ff <= acc_word;
               end
               if (word_end && slot == SLOT_FRACTION) begin
                  fraction_ff <= acc_word;
               end
               if (word_end && slot == SLOT_CAPTURED) begin
                  captured_ff <= acc_word;
               end
               if (word_end && slot == SLOT_ORIGINAL) begin
                  original_ff <= acc_word;
               end
               if (record_done) begin
                  remaining_ff <= captured_ff[26:0];
               end
            end
            PHASE_DATA: begin
               remaining_ff <= remaining_ff - 27'd1;
            end
            default: begin
               shift_ff <= shift_ff;
            end
         endcase
      end
   end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the capture-file deframer. A queue of stream beats
// (one capture file with random content and a randomly chosen ending, then
// trailing noise) feeds a valid/ready driver. An in-bench parser predicts
// each result, and a monitor checks every result beat field by field.
// ----------------------------------------------------------------------------
module tb;
   import pcapd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic            clock            = 1'b0;
   logic            reset            = 1'b1;
   logic            csr_write_enable = 1'b0;
   logic [31:0]     csr_write_data   = '0;
   logic            req_valid        = 1'b0;
   logic            req_ready;
   req_payload_type req_payload      = '0;
   logic            rsp_valid;
   logic            rsp_ready        = 1'b0;
   rsp_payload_type rsp_payload;

   // stimulus and scoreboard storage
   req_payload_type byte_backlog[$];
   rsp_payload_type deframed_results[$];
   logic [7:0]      staged[$];

   int   cycle_count = 0;
   int   beats_in    = 0;
   int   fault_count = 0;
   logic beat_taken  = 1'b0;

   // layout of the file being generated
   logic file_le   = 1'b0;
   logic file_long = 1'b0;
   int   hdr_len   = 16;

   // parser state mirrored by the bench
   phase_type   parse_phase   = PHASE_GLOBAL;
   logic [4:0]  header_pos    = '0;
   logic [31:0] byte_window   = '0;
   logic        le_flag       = 1'b0;
   logic        ns_flag       = 1'b0;
   logic        long_record   = 1'b0;
   logic        magic_ok      = 1'b0;
   logic [31:0] version_seen  = '0;
   logic [31:0] snap_seen     = '0;
   logic [31:0] link_seen     = '0;
   logic [31:0] seconds_seen  = '0;
   logic [31:0] fraction_seen = '0;
   logic [31:0] captured_seen = '0;
   logic [31:0] original_seen = '0;
   logic [26:0] bytes_left    = '0;
   logic [31:0] link_required = LINK_TYPE_RESET;

   pcap_stream_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Word as stored in the file, in host order
   function automatic logic [31:0] file_word(logic [31:0] w);
      return le_flag ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
   endfunction

   // Advance the parser by one beat and queue the result it gives, if any
   function automatic void deframe_byte(req_payload_type beat);
      rsp_payload_type outcome;
      logic            produce;
      logic [4:0]      pos;
      logic [4:0]      last_pos;
      outcome  = '0;
      produce  = 1'b0;
      pos      = header_pos;
      last_pos = long_record ? LONG_RECORD_LAST_BYTE : SHORT_RECORD_LAST_BYTE;
      case (parse_phase)
         PHASE_GLOBAL: begin
            produce = (beat.cmd == CMD_END) || (pos == GLOBAL_LAST_BYTE);
            if (beat.cmd == CMD_END) begin
               outcome.kind       = KIND_ERROR;
               outcome.error_code = ERR_SHORT_GLOBAL;
            end else begin
               byte_window = {byte_window[23:0], beat.stream_byte};
               header_pos  = pos + 5'd1;
               if (pos[1:0] == 2'd3) begin
                  case (pos[4:2])
                     SLOT_MAGIC: begin
                        magic_ok = 1'b1;
                        case (byte_window)
                           MAGIC_LE_USEC: begin le_flag = 1'b1; ns_flag = 1'b0; end
                           MAGIC_BE_USEC: begin le_flag = 1'b0; ns_flag = 1'b0; end
                           MAGIC_LE_NSEC: begin le_flag = 1'b1; ns_flag = 1'b1; end
                           MAGIC_BE_NSEC: begin le_flag = 1'b0; ns_flag = 1'b1; end
                           MAGIC_LE_MODIFIED: begin
                              le_flag = 1'b1; ns_flag = 1'b0; long_record = 1'b1;
                           end
                           MAGIC_BE_MODIFIED: begin
                              le_flag = 1'b0; ns_flag = 1'b0; long_record = 1'b1;
                           end
                           default: magic_ok = 1'b0;
                        endcase
                     end
                     // major and minor are 16-bit fields, swapped in place
                     SLOT_VERSION: version_seen = le_flag ?
                        {byte_window[23:16], byte_window[31:24],
                         byte_window[7:0], byte_window[15:8]} : byte_window;
                     SLOT_SNAP: snap_seen = file_word(byte_window);
                     SLOT_LINK: link_seen = file_word(byte_window);
                     default: ;
                  endcase
               end
               // checks run only once the whole header is in
               if (pos == GLOBAL_LAST_BYTE) begin
                  header_pos = '0;
                  if (!magic_ok) begin
                     outcome.kind       = KIND_ERROR;
                     outcome.error_code = ERR_MAGIC;
                  end else if (link_seen != link_required) begin
                     outcome.kind       = KIND_ERROR;
                     outcome.error_code = ERR_LINK;
                  end else if (snap_seen == 0 || snap_seen > MAX_CAPTURE_WORD) begin
                     outcome.kind       = KIND_ERROR;
                     outcome.error_code = ERR_SNAPLEN;
                  end else begin
                     parse_phase             = PHASE_RECORD;
                     outcome.kind            = KIND_GLOBAL;
                     outcome.format_version  = version_seen;
                     outcome.snapshot_length = snap_seen[26:0];
                  end
               end
            end
         end
         PHASE_RECORD: begin
            produce = (beat.cmd == CMD_END) || (pos == last_pos);
            if (beat.cmd == CMD_END) begin
               if (pos == 0) begin
                  outcome.kind = KIND_END;
               end else begin
                  outcome.kind       = KIND_ERROR;
                  outcome.error_code = ERR_SHORT_RECORD;
               end
            end else begin
               byte_window = {byte_window[23:0], beat.stream_byte};
               header_pos  = pos + 5'd1;
               if (pos[1:0] == 2'd3) begin
                  case (pos[4:2])
                     SLOT_SECONDS:  seconds_seen  = file_word(byte_window);
                     SLOT_FRACTION: fraction_seen = file_word(byte_window);
                     SLOT_CAPTURED: captured_seen = file_word(byte_window);
                     SLOT_ORIGINAL: original_seen = file_word(byte_window);
                     default: ;
                  endcase
               end
               if (pos == last_pos) begin
                  header_pos = '0;
                  if (captured_seen > snap_seen || captured_seen > MAX_CAPTURE_WORD) begin
                     outcome.kind       = KIND_ERROR;
                     outcome.error_code = ERR_CAPLEN;
                  end else begin
                     bytes_left              = captured_seen[26:0];
                     parse_phase = (bytes_left != 0) ? PHASE_DATA : PHASE_RECORD;
                     outcome.kind            = KIND_RECORD;
                     outcome.stamp_seconds   = seconds_seen;
                     outcome.stamp_fraction  = fraction_seen;
                     outcome.captured_length = captured_seen[26:0];
                     outcome.original_length = original_seen;
                  end
               end
            end
         end
         PHASE_DATA: begin
            produce = 1'b1;
            if (beat.cmd == CMD_END) begin
               outcome.kind       = KIND_ERROR;
               outcome.error_code = ERR_SHORT_DATA;
            end else begin
               outcome.kind           = KIND_DATA;
               outcome.packet_byte    = beat.stream_byte;
               outcome.last_of_packet = (bytes_left == 1);
               bytes_left             = bytes_left - 27'd1;
               if (bytes_left == 0)
                  parse_phase = PHASE_RECORD;
            end
         end
         default: ;
      endcase
      if (produce) begin
         outcome.little_endian     = le_flag;
         outcome.nanosecond_stamps = ns_flag;
         if (outcome.kind == KIND_ERROR || outcome.kind == KIND_END)
            parse_phase = PHASE_STOP;
         deframed_results.push_back(outcome);
      end
   endfunction

   function automatic void match_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         fault_count++;
         if (fault_count <= 10)
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      end
   endfunction

   function automatic void check_result(rsp_payload_type want, rsp_payload_type got);
      match_field("kind",              want.kind,              got.kind);
      match_field("error_code",        want.error_code,        got.error_code);
      match_field("little_endian",     want.little_endian,     got.little_endian);
      match_field("nanosecond_stamps", want.nanosecond_stamps, got.nanosecond_stamps);
      match_field("format_version",    want.format_version,    got.format_version);
      match_field("snapshot_length",   want.snapshot_length,   got.snapshot_length);
      match_field("stamp_seconds",     want.stamp_seconds,     got.stamp_seconds);
      match_field("stamp_fraction",    want.stamp_fraction,    got.stamp_fraction);
      match_field("captured_length",   want.captured_length,   got.captured_length);
      match_field("original_length",   want.original_length,   got.original_length);
      match_field("packet_byte",       want.packet_byte,       got.packet_byte);
      match_field("last_of_packet",    want.last_of_packet,    got.last_of_packet);
   endfunction

   function automatic logic calm_stretch();
      return beats_in >= 500 && beats_in < 800;
   endfunction

   function automatic void push_beat(cmd_type cmd, logic [7:0] b);
      req_payload_type item;
      item.cmd         = cmd;
      item.stream_byte = b;
      byte_backlog.push_back(item);
   endfunction

   // Stage a word in file order, high byte first or low byte first
   function automatic void stage_word(logic [31:0] w, logic msb_first);
      for (int i = 0; i < 4; i++)
         staged.push_back(msb_first ? w[31 - 8 * i -: 8] : w[8 * i +: 8]);
   endfunction

   // Send the first keep staged bytes and drop the rest
   function automatic void flush_staged(int keep);
      for (int i = 0; i < keep && i < staged.size(); i++)
         push_beat(CMD_BYTE, staged[i]);
      staged.delete();
   endfunction

   // One record: header cut to hdr_keep bytes, then data_keep random data bytes
   function automatic int push_record(logic [31:0] secs, logic [31:0] frac,
                                      logic [31:0] cap, logic [31:0] orig,
                                      int hdr_keep, int data_keep);
      stage_word(secs, !file_le);
      stage_word(frac, !file_le);
      stage_word(cap,  !file_le);
      stage_word(orig, !file_le);
      if (file_long) begin
         stage_word($urandom, 1'b1);
         stage_word($urandom, 1'b1);
      end
      flush_staged(hdr_keep);
      for (int i = 0; i < data_keep; i++)
         push_beat(CMD_BYTE, 8'($urandom));
      return hdr_keep + data_keep;
   endfunction

   // Wait until every beat is in and every result is out
   task automatic drain();
      do
         @(posedge clock);
      while (byte_backlog.size() != 0 || req_valid || deframed_results.size() != 0);
      repeat (6) @(negedge clock);
   endtask

   task automatic write_link_type(logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      link_required = value;
   endtask

   // Drive beats from the backlog and randomize result back-pressure
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         // hold an offered beat until it is taken
         if (!req_valid || beat_taken) begin
            if (byte_backlog.size() != 0 && (calm_stretch() || $urandom_range(99) >= 17)) begin
               req_valid   <= 1'b1;
               req_payload <= byte_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= calm_stretch() || ($urandom_range(99) >= 17);
      end
      beat_taken = 1'b0;
   end

   // Predict on accepted beats, check accepted results, watch the clock budget
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_results.size() == 0) begin
               fault_count++;
               if (fault_count <= 10)
                  $display("%0t: result with none pending, kind %0d", $time, rsp_payload.kind);
            end else begin
               check_result(deframed_results.pop_front(), rsp_payload);
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_payload);
            beats_in++;
            beat_taken = 1'b1;
         end
      end
   end

   initial begin
      logic [31:0] magic_set [6];
      logic [31:0] magic;
      logic [31:0] link_value;
      logic [31:0] snap_value;
      logic [31:0] header_link;
      logic [31:0] header_snap;
      logic [31:0] batch_link [4];
      logic [31:0] bad_cap;
      logic [15:0] major;
      logic [15:0] minor;
      int          magic_idx;
      int          plan;
      int          pick;
      int          keep;
      int          data_cap;
      int          batch_bytes;
      int          cap;

      magic_set = '{MAGIC_LE_USEC, MAGIC_BE_USEC, MAGIC_LE_NSEC,
                    MAGIC_BE_NSEC, MAGIC_LE_MODIFIED, MAGIC_BE_MODIFIED};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // link type the header will carry; sometimes keep the reset value
      pick = $urandom_range(0, 3);
      case (pick)
         0:       link_value = LINK_TYPE_RESET;
         1:       link_value = 32'h0000_0000;
         2:       link_value = 32'hffff_ffff;
         default: link_value = $urandom;
      endcase
      if (pick != 0)
         write_link_type(link_value);

      magic_idx = $urandom_range(0, 5);
      magic     = magic_set[magic_idx];
      file_le   = (magic_idx % 2) == 0;
      file_long = magic_idx >= 4;
      hdr_len   = file_long ? 24 : 16;

      pick = $urandom_range(0, 9);
      if (pick < 5)
         snap_value = MAX_CAPTURE_WORD;
      else if (pick < 7)
         snap_value = 32'd1;
      else if (pick < 9)
         snap_value = $urandom_range(2, 300);
      else
         snap_value = $urandom_range(2, MAX_CAPTURE_BYTES);
      data_cap = (snap_value < 40) ? int'(snap_value) : 40;

      // mostly a good file; a few broken global headers
      plan        = $urandom_range(0, 99);
      header_link = link_value;
      header_snap = snap_value;
      keep        = 24;
      if (plan < 2) begin
         keep = $urandom_range(0, 23);
         if ($urandom_range(0, 1) == 1)
            magic = $urandom;
      end else if (plan < 4) begin
         do
            magic = $urandom;
         while (magic inside {MAGIC_LE_USEC, MAGIC_BE_USEC, MAGIC_LE_NSEC,
                              MAGIC_BE_NSEC, MAGIC_LE_MODIFIED, MAGIC_BE_MODIFIED});
      end else if (plan < 6) begin
         header_link = link_value ^ (32'd1 << $urandom_range(0, 31));
      end else if (plan < 8) begin
         pick = $urandom_range(0, 2);
         header_snap = (pick == 0) ? 32'd0 :
                       (pick == 1) ? MAX_CAPTURE_WORD + 32'd1 : 32'hffff_ffff;
      end

      // global header
      major = 16'($urandom);
      minor = 16'($urandom);
      stage_word(magic, 1'b1);
      stage_word(file_le ? {major[7:0], major[15:8], minor[7:0], minor[15:8]} : {major, minor},
                 1'b1);
      stage_word($urandom, 1'b1);
      stage_word($urandom, 1'b1);
      stage_word(header_snap, !file_le);
      stage_word(header_link, !file_le);
      flush_staged(keep);
      if (plan < 2)
         push_beat(CMD_END, 8'($urandom));
      drain();
      write_link_type(32'hffff_ffff);

      if (plan >= 8) begin
         // edge records: empty, single byte, and as long as the data cap allows
         void'(push_record(32'hffff_ffff, 32'h0, 32'd0, 32'hffff_ffff, hdr_len, 0));
         void'(push_record(32'h0, 32'hffff_ffff, 32'd1, 32'h0, hdr_len, 1));
         void'(push_record($urandom, $urandom, data_cap, $urandom, hdr_len, data_cap));

         // random records in batches, with a register write between batches
         batch_link = '{32'h0000_0000, $urandom, LINK_TYPE_RESET, 32'hffff_ffff};
         for (int batch = 0; batch < 4; batch++) begin
            batch_bytes = 0;
            while (batch_bytes < 380) begin
               cap = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, data_cap);
               batch_bytes += push_record($urandom, $urandom, cap, $urandom, hdr_len, cap);
            end
            drain();
            write_link_type(batch_link[batch]);
         end

         // close the file: clean end, cut header, cut data or bad length
         pick = $urandom_range(0, 9);
         if (pick < 5) begin
            push_beat(CMD_END, 8'($urandom));
         end else if (pick < 7) begin
            void'(push_record($urandom, $urandom, 32'd0, $urandom,
                              $urandom_range(1, hdr_len - 1), 0));
            push_beat(CMD_END, 8'($urandom));
         end else if (pick < 8) begin
            cap = $urandom_range(1, data_cap);
            void'(push_record($urandom, $urandom, cap, $urandom, hdr_len,
                              $urandom_range(0, cap - 1)));
            push_beat(CMD_END, 8'($urandom));
         end else begin
            pick = $urandom_range(0, 2);
            bad_cap = (pick == 0) ? snap_value + 32'd1 :
                      (pick == 1) ? 32'hffff_ffff : MAX_CAPTURE_WORD + 32'd1;
            void'(push_record($urandom, $urandom, bad_cap, $urandom, hdr_len, 0));
         end
      end

      // beats after the parser stopped must give nothing
      for (int i = 0; i < 16; i++)
         push_beat(($urandom_range(0, 3) == 0) ? CMD_END : CMD_BYTE, 8'($urandom));
      drain();
      repeat (8) @(negedge clock);

      if (fault_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
